### sv/median_of_score_set_unit_macros.svh
// assertion macros for the median of score set unit
// expects a clock i_clk and an active-low reset i_rst_n in the using module
`ifndef MEDIAN_OF_SCORE_SET_UNIT_MACROS_SVH
`define MEDIAN_OF_SCORE_SET_UNIT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define MOS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// condition that must never hold outside reset
`define MOS_NEVER(label, cond, msg) \
    `MOS_ASSERT(label, !(cond), msg)

`endif

### sv/mos_pkg.sv
// shared types and constants of the median of score set unit
// no dependencies
`timescale 1ns / 1ps

package mos_pkg;

    localparam int MAX_SCORES  = 64;
    localparam int SCORE_W     = 32;
    localparam int CNT_W       = $clog2(MAX_SCORES + 1);
    localparam int OUT_CNT_W   = 7;
    localparam int OUT_DATA_W  = 40;

    typedef logic signed [SCORE_W-1:0] t_score;

    // control broadcast to every cell of the chain
    typedef struct packed {
        logic insert;
        logic shift;
    } t_cell_ctl;

    typedef enum logic {
        ST_FILL,
        ST_SHIFT
    } t_state;

endpackage

### sv/mos_cell.sv
// one cell of the sorted chain: holds one score, takes part in insertion and shift-down
// depends on mos_pkg
`timescale 1ns / 1ps

module mos_cell (
    input  logic               i_clk,
    input  mos_pkg::t_cell_ctl i_ctl,
    input  mos_pkg::t_score    i_score,
    input  logic               i_empty,
    input  mos_pkg::t_score    i_prev_val,
    input  logic               i_prev_gt,
    input  mos_pkg::t_score    i_next_val,
    output mos_pkg::t_score    o_val,
    output logic               o_gt
);
    import mos_pkg::*;

    t_score r_val;
    t_score n_val;

    // cell moves up when empty or holding a larger value than the new score
    always_comb begin
        o_gt = i_empty | (r_val > i_score);
    end

    // take the neighbour's value or the new score on insert, the upper neighbour on shift
    always_comb begin
        n_val = r_val;
        if (i_ctl.insert && o_gt) begin
            n_val = i_prev_gt ? i_prev_val : i_score;
        end else if (i_ctl.shift) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

### sv/mos_chain.sv
// row of sorted cells, ascending from cell 0, filled below the current count
// depends on mos_pkg and mos_cell
`timescale 1ns / 1ps

module mos_chain (
    input  logic               i_clk,
    input  mos_pkg::t_cell_ctl i_ctl,
    input  mos_pkg::t_score    i_score,
    input  logic [mos_pkg::CNT_W-1:0] i_count,
    output mos_pkg::t_score    o_low,
    output mos_pkg::t_score    o_second
);
    import mos_pkg::*;

    t_score w_val [MAX_SCORES];
    logic   w_gt  [MAX_SCORES];

    // cells linked to their neighbours
    for (genvar g = 0; g < MAX_SCORES; g++) begin : g_cell
        t_score w_prev_val;
        logic   w_prev_gt;
        t_score w_next_val;
        logic   w_empty;

        if (g == 0) begin : g_first
            assign w_prev_val = i_score;
            assign w_prev_gt  = 1'b0;
        end else begin : g_inner
            assign w_prev_val = w_val[g-1];
            assign w_prev_gt  = w_gt[g-1];
        end

        if (g == MAX_SCORES - 1) begin : g_top
            assign w_next_val = w_val[g];
        end else begin : g_below
            assign w_next_val = w_val[g+1];
        end

        assign w_empty = (CNT_W'(g) >= i_count);

        mos_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (i_ctl),
            .i_score    (i_score),
            .i_empty    (w_empty),
            .i_prev_val (w_prev_val),
            .i_prev_gt  (w_prev_gt),
            .i_next_val (w_next_val),
            .o_val      (w_val[g]),
            .o_gt       (w_gt[g])
        );
    end

    // the two lowest cells carry the median after the shift-down
    assign o_low = w_val[0];
    if (MAX_SCORES > 1) begin : g_two
        assign o_second = w_val[1];
    end else begin : g_one
        assign o_second = w_val[0];
    end

endmodule

### sv/median_of_score_set_unit.sv
// top level of the median of score set unit: handshakes, set control, result register
// depends on mos_pkg, mos_chain and median_of_score_set_unit_macros.svh
`timescale 1ns / 1ps

// Scores enter one beat per cycle while the unit is filling and are inserted
// in order into a row of MAX_SCORES cells. The beat with tlast closes the
// set; the row then shifts down (n-1)/2 places for a set of n scores so the
// middle values reach the lowest two cells, and the result register is then
// loaded once the previous result has been taken. Input is held off during
// the shift-down and that wait. Scores beyond MAX_SCORES are dropped and
// flagged. An even count gives the floor of the mean of the two middle
// values. A new set may load while the previous result still waits on the
// master side.
module median_of_score_set_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [mos_pkg::SCORE_W-1:0]    i_s_tdata,  // [31:0] score
    input  logic                           i_s_tlast,  // last
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [mos_pkg::OUT_DATA_W-1:0] o_m_tdata   // [31:0] median, [38:32] count_used,
                                                       // [39] overflow
);
    import mos_pkg::*;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic                r_drop,  n_drop;
    logic [CNT_W-1:0]    r_k,     n_k;
    logic                r_out_valid, n_out_valid;
    logic                w_load;
    t_score              r_out_median;
    logic [OUT_CNT_W-1:0] r_out_count;
    logic                r_out_drop;

    t_cell_ctl           w_ctl;
    t_score              w_low, w_second;
    logic                w_acc, w_room;
    logic [CNT_W-1:0]    w_count_after;
    logic [SCORE_W:0]    w_sum;
    t_score              w_median;
    logic [CNT_W+OUT_CNT_W-1:0] w_count_ext;

    assign w_acc  = i_s_tvalid & o_s_tready;
    assign w_room = (r_count < CNT_W'(MAX_SCORES));
    assign w_count_after = w_room ? (r_count + CNT_W'(1)) : r_count;

    // sorted row of cells
    mos_chain u_chain (
        .i_clk    (i_clk),
        .i_ctl    (w_ctl),
        .i_score  (t_score'(i_s_tdata)),
        .i_count  (r_count),
        .o_low    (w_low),
        .o_second (w_second)
    );

    // median from the two lowest cells
    assign w_sum    = {w_low[SCORE_W-1], w_low} + {w_second[SCORE_W-1], w_second};
    assign w_median = r_count[0] ? w_low : t_score'(w_sum[SCORE_W:1]);
    assign w_count_ext = {{OUT_CNT_W{1'b0}}, r_count};

    // set control: fill, then shift down and hand over the result
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_drop      = r_drop;
        n_k         = r_k;
        n_out_valid = r_out_valid & ~i_m_tready;
        w_ctl       = '0;
        w_load      = 1'b0;
        o_s_tready  = (r_state == ST_FILL);
        case (r_state)
            ST_FILL: begin
                if (w_acc) begin
                    if (w_room) begin
                        w_ctl.insert = 1'b1;
                        n_count      = w_count_after;
                    end else begin
                        n_drop = 1'b1;
                    end
                    if (i_s_tlast) begin
                        n_k     = (w_count_after - CNT_W'(1)) >> 1;
                        n_state = ST_SHIFT;
                    end
                end
            end
            ST_SHIFT: begin
                if (r_k != '0) begin
                    w_ctl.shift = 1'b1;
                    n_k         = r_k - CNT_W'(1);
                end else if (!r_out_valid || i_m_tready) begin
                    w_load      = 1'b1;
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_drop      = 1'b0;
                    n_state     = ST_FILL;
                end
            end
            default: begin
                n_state = ST_FILL;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FILL;
            r_count     <= '0;
            r_drop      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_drop      <= n_drop;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_median <= w_median;
            r_out_count  <= w_count_ext[OUT_CNT_W-1:0];
            r_out_drop   <= r_drop;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {r_out_drop, r_out_count, r_out_median};

    // checks
    `include "median_of_score_set_unit_macros.svh"

    `MOS_NEVER(a_count_bound, r_count > CNT_W'(MAX_SCORES), "score count beyond capacity")
    `MOS_ASSERT(a_last_shift, (w_acc && i_s_tlast) |=> r_state == ST_SHIFT, "no shift after tlast")
    `MOS_ASSERT(a_full_drop, (w_acc && !w_room) |=> r_drop, "dropped score not flagged")
    `MOS_ASSERT(a_out_nonempty, r_out_valid |-> (r_out_count != '0), "result with empty set")

endmodule
